// ===== rtl/spq_pkg.sv =====
// types and codes shared by the sorted priority queue and its cells
package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] item_data;
        logic signed [PRIO_W-1:0] item_priority;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] head_data;
        logic                     queue_empty;
        logic [COUNT_W-1:0]       entry_count;
        logic [STAT_W-1:0]        status;
    } t_out;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } t_cell_cmd;

endpackage

// ===== rtl/spq_cell.sv =====
// one slot of the sorted chain: compare against the new entry and shift
module spq_cell
    import spq_pkg::*;
#(
    parameter bit HEAD = 1'b0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_slot     i_left_slot,
    input  logic      i_left_keep,
    input  t_slot     i_right_slot,
    output t_slot     o_slot,
    output logic      o_keep
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_data;
    logic signed [PRIO_W-1:0] r_prio;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_data;
    logic signed [PRIO_W-1:0] n_prio;
    logic                     w_keep;

    // head yields only to a strictly smaller priority
    always_comb begin
        if (HEAD) begin
            w_keep = r_valid && !(i_cmd.prio < r_prio);
        end else begin
            w_keep = r_valid && (r_prio < i_cmd.prio);
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_prio  = r_prio;
        if (i_cmd.insert && !w_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_data  = i_cmd.data;
                n_prio  = i_cmd.prio;
            end else begin
                n_valid = i_left_slot.valid;
                n_data  = i_left_slot.data;
                n_prio  = i_left_slot.prio;
            end
        end else if (i_cmd.remove) begin
            n_valid = i_right_slot.valid;
            n_data  = i_right_slot.data;
            n_prio  = i_right_slot.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_slot = '{valid: r_valid, data: r_data, prio: r_prio};
    assign o_keep = w_keep;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// top level of the sorted priority queue: cell chain, count and result register
//
// Sorted priority queue of DEPTH entries held in a chain of compare-and-shift
// cells, smallest priority at the head. Each request is an insert, a remove of
// the head, or a status read, and returns one result with the head data, empty
// flag, count and status after the operation. Every cell compares its priority
// with the new one and shifts toward the tail or the head in the same cycle, so
// one request is accepted per clock while the result register is free or being
// taken. An insert into a full queue is dropped with overflow status, a remove
// from an empty queue reports underflow. Ties keep the newer entry ahead of
// older ones of equal priority, except that the head is never displaced by an
// equal priority.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_cell_cmd         w_cmd;
    t_slot             w_slot [DEPTH];
    logic              w_keep [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_cmd.insert = w_accept && (i_in.func == FUNC_INSERT) && !w_full;
        w_cmd.remove = w_accept && (i_in.func == FUNC_REMOVE) && !w_empty;
        w_cmd.data   = i_in.item_data;
        w_cmd.prio   = i_in.item_priority;
    end

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        unique case (i_in.func)
            FUNC_INSERT: begin
                if (w_full) begin
                    n_status = STAT_OVERFLOW;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_REMOVE: begin
                if (w_empty) begin
                    n_status = STAT_UNDERFLOW;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_keep;

        if (g == 0) begin : g_first
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left      = w_slot[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        spq_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left_slot  (w_left),
            .i_left_keep  (w_left_keep),
            .i_right_slot (w_right),
            .o_slot       (w_slot[g]),
            .o_keep       (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    // cells hold still while a result waits, so the head is read straight off cell zero
    always_comb begin
        o_out.head_data   = w_slot[0].valid ? w_slot[0].data : '0;
        o_out.queue_empty = (r_count == '0);
        o_out.entry_count = COUNT_W'(r_count);
        o_out.status      = r_status;
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the sorted priority queue with random idling on both sides
module tb
    import spq_pkg::*;
();

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_WAIT    = 17;
    localparam int RANDOM_REQS = 1500;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_req = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    int in_gap = 0;
    int out_hold = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int errors = 0;

    t_in requests_to_send[$];
    t_out results_due[$];

    logic signed [DATA_W-1:0] shadow_data [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
    int shadow_count = 0;

    sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // applies one request to the shadow queue and returns the view after it
    function automatic t_out serve_request(t_in req);
        t_out view;
        int pos;
        logic [STAT_W-1:0] st;
        st = STAT_OK;
        if (req.func == FUNC_INSERT) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                st = STAT_OVERFLOW;
            end else begin
                if (shadow_count == 0 || req.item_priority < shadow_prio[0]) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_count && shadow_prio[pos] < req.item_priority)
                        pos++;
                end
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_data[k] = shadow_data[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_data[pos] = req.item_data;
                shadow_prio[pos] = req.item_priority;
                shadow_count++;
            end
        end else if (req.func == FUNC_REMOVE) begin
            if (shadow_count == 0) begin
                st = STAT_UNDERFLOW;
            end else begin
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_data[k-1] = shadow_data[k];
                    shadow_prio[k-1] = shadow_prio[k];
                end
                shadow_count--;
            end
        end
        view.head_data   = (shadow_count > 0) ? shadow_data[0] : '0;
        view.queue_empty = (shadow_count == 0);
        view.entry_count = shadow_count[COUNT_W-1:0];
        view.status      = st;
        return view;
    endfunction

    task automatic push_request(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] d,
                                logic signed [PRIO_W-1:0] p);
        t_in req;
        req.func = f;
        req.item_data = d;
        req.item_priority = p;
        requests_to_send.push_back(req);
    endtask

    function automatic t_in random_request(t_mix mix);
        t_in req;
        int roll;
        int pick;
        roll = $urandom_range(0, 9);
        case (mix)
            MIX_FILL:  req.func = (roll < 7) ? FUNC_INSERT : (roll < 9) ? FUNC_REMOVE : FUNC_STATUS;
            MIX_DRAIN: req.func = (roll < 7) ? FUNC_REMOVE : (roll < 9) ? FUNC_INSERT : FUNC_STATUS;
            default:   req.func = (roll < 4) ? FUNC_INSERT : (roll < 8) ? FUNC_REMOVE : FUNC_STATUS;
        endcase
        if (req.func == FUNC_STATUS && $urandom_range(0, 1))
            req.func = FUNC_SPARE;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            req.item_data = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        else
            req.item_data = $urandom();
        pick = $urandom_range(0, 9);
        if (pick < 2)
            req.item_priority = PRIO_W'($urandom());
        else if (pick == 2)
            req.item_priority = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else
            req.item_priority = PRIO_W'(int'($urandom_range(0, 6)) - 3);
        return req;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_in next_req;
        logic next_valid;
        int next_gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            next_req = in_req;
            next_valid = in_valid;
            next_gap = in_gap;
            if (in_valid && !o_in_stall) begin
                results_due.push_back(serve_request(in_req));
                next_valid = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    in_calm = !in_calm;
                next_gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!next_valid) begin
                if (next_gap > 0) begin
                    next_gap--;
                end else if (requests_to_send.size() != 0) begin
                    next_req = requests_to_send.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
            in_req <= next_req;
            in_gap <= next_gap;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        int next_hold;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            out_hold <= 0;
        end else begin
            next_hold = out_hold;
            if (o_out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: head %0d empty %0b count %0d status %0d",
                                 o_out.head_data, o_out.queue_empty, o_out.entry_count,
                                 o_out.status);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (o_out.head_data !== want.head_data
                            || o_out.queue_empty !== want.queue_empty
                            || o_out.entry_count !== want.entry_count
                            || o_out.status !== want.status) begin
                        if (errors < 10)
                            $display({"mismatch: expected head %0d empty %0b count %0d ",
                                      "status %0d, got head %0d empty %0b count %0d status %0d"},
                                     want.head_data, want.queue_empty, want.entry_count,
                                     want.status, o_out.head_data, o_out.queue_empty,
                                     o_out.entry_count, o_out.status);
                        errors++;
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    out_calm = !out_calm;
                next_hold = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (next_hold > 0) begin
                out_stall <= 1'b1;
                out_hold <= next_hold - 1;
            end else begin
                out_stall <= 1'b0;
                out_hold <= 0;
            end
        end
    end

    initial begin
        t_mix mix;
        // empty queue cases
        push_request(FUNC_STATUS, 32'sd0, 16'sd0);
        push_request(FUNC_REMOVE, 32'sh7fffffff, 16'sh7fff);
        // ties with the head and behind the head
        push_request(FUNC_INSERT, 32'sh7fffffff, 16'sd0);
        push_request(FUNC_INSERT, 32'sh80000000, 16'sd0);
        push_request(FUNC_INSERT, 32'sd1, 16'sd0);
        push_request(FUNC_INSERT, -32'sd1, 16'sh8000);
        push_request(FUNC_INSERT, 32'sd2, 16'sh7fff);
        push_request(FUNC_SPARE, 32'sd3, 16'sh8000);
        for (int k = 0; k < 10; k++)
            push_request(FUNC_INSERT, $urandom(), PRIO_W'(k - 5));
        // full queue
        push_request(FUNC_INSERT, 32'sh12345678, 16'sh8000);
        push_request(FUNC_STATUS, 32'sh80000000, 16'sh7fff);
        push_request(FUNC_REMOVE, 32'sd0, 16'sd0);
        push_request(FUNC_INSERT, 32'sh0badcafe, 16'sh7fff);

        mix = MIX_EVEN;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 40 == 0)
                mix = t_mix'($urandom_range(0, 2));
            requests_to_send.push_back(random_request(mix));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_to_send.size() != 0 || in_valid)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb.sv
